// ===== sv/hcb_pkg.sv =====
`timescale 1ns / 1ps

package hcb_pkg;

	// node weights hold a sum of up to 256 counts of 24 bits
	localparam int WEIGHT_BITS = 32;
	localparam int CODE_LEN_BITS = 6;
	localparam int CODE_OUT_BITS = 64;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QUERY,
		ST_LEAF,
		ST_LEAF_END,
		ST_SCAN,
		ST_SCAN_END,
		ST_LINK_A,
		ST_LINK_B,
		ST_NEW,
		ST_CODE_RD,
		ST_CODE_CHK,
		ST_CODE_WR,
		ST_REPORT
	} state_t;

	// control of the minimum-pair tracker during a node scan
	typedef struct packed {
		logic clr;
		logic v;
		logic linked;
	} scan_ctl_t;

endpackage

// ===== sv/hcb_min_pair.sv =====
`timescale 1ns / 1ps

module hcb_min_pair #(
	parameter int IDX_BITS = 9
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  hcb_pkg::scan_ctl_t               ctl,
	input  logic [IDX_BITS-1:0]              idx,
	input  logic [hcb_pkg::WEIGHT_BITS-1:0]  weight,
	output logic [IDX_BITS-1:0]              a_idx,
	output logic [hcb_pkg::WEIGHT_BITS-1:0]  a_w,
	output logic [IDX_BITS-1:0]              b_idx,
	output logic [hcb_pkg::WEIGHT_BITS-1:0]  b_w
);

	logic has_a_q, has_b_q;
	logic [IDX_BITS-1:0] a_idx_q, b_idx_q;
	logic [hcb_pkg::WEIGHT_BITS-1:0] a_w_q, b_w_q;

	// presence flags of the two tracked candidates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_a_q <= 1'b0;
			has_b_q <= 1'b0;
		end else if (ctl.clr) begin
			has_a_q <= 1'b0;
			has_b_q <= 1'b0;
		end else if (ctl.v && !ctl.linked) begin
			if (!has_a_q || weight < a_w_q) begin
				has_a_q <= 1'b1;
				has_b_q <= has_a_q;
			end else if (!has_b_q || weight < b_w_q) begin
				has_b_q <= 1'b1;
			end
		end
	end

	// strict compares in ascending index order keep the lowest index on ties
	always_ff @(posedge clk) begin
		if (!ctl.clr && ctl.v && !ctl.linked) begin
			if (!has_a_q || weight < a_w_q) begin
				b_idx_q <= a_idx_q;
				b_w_q   <= a_w_q;
				a_idx_q <= idx;
				a_w_q   <= weight;
			end else if (!has_b_q || weight < b_w_q) begin
				b_idx_q <= idx;
				b_w_q   <= weight;
			end
		end
	end

	assign a_idx = a_idx_q;
	assign a_w   = a_w_q;
	assign b_idx = b_idx_q;
	assign b_w   = b_w_q;

endmodule

// ===== sv/huffman_code_builder.sv =====
`timescale 1ns / 1ps

// Huffman code builder. A load request (tuser 0) stores one symbol's count; a
// query request (tuser 2) answers from the code table of the last build. A
// build request (tuser 1) runs a sequencer over a single-ported node memory: a
// leaf pass over all SYMBOL_COUNT symbols, then for each of the n-1 merges one
// scan of all open nodes through a shared minimum-pair unit, then a walk from
// each leaf to the root, one level at a time, that closes with a write of the
// leaf's code. Input is not taken while a request is at work; a finished result
// waits in the output register.
module huffman_code_builder #(
	parameter int SYMBOL_COUNT  = 256,
	parameter int COUNT_BITS    = 24,
	parameter int MAX_CODE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // symbol[7:0], count[31:8]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// leaf_total[8:0], symbol_out[16:9], present[17], code_length[23:18],
	// code_bits[87:24]
	output logic [87:0] m_tdata,
	output logic        m_tuser    // result_kind[0]
);

	localparam int CAP   = (MAX_CODE_BITS < 63) ? MAX_CODE_BITS : 63;
	localparam int NODES = 2 * SYMBOL_COUNT - 1;
	localparam int NW    = $clog2(NODES);
	localparam int SW    = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int CNW   = $clog2(SYMBOL_COUNT + 1);
	localparam int WB    = hcb_pkg::WEIGHT_BITS;
	localparam int LB    = hcb_pkg::CODE_LEN_BITS;

	hcb_pkg::state_t state_q, state_d;

	// storage
	logic [COUNT_BITS-1:0] cnt_mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] cnt_v_q;
	logic [WB:0] wmem [NODES];          // {linked, weight}
	logic [NW:0] pmem [NODES];          // {is_right, parent}
	logic [SW-1:0] lmem [SYMBOL_COUNT]; // leaf to symbol
	logic [LB+CAP-1:0] cmem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] present_q;

	logic [WB:0] wrd_q;
	logic [NW:0] prd_q;
	logic [SW-1:0] lrd_q;
	logic [LB+CAP-1:0] crd_q;

	// sequencer registers
	logic [CNW-1:0] n_q, i_q;
	logic [NW-1:0] top_q, k_q, c_q, depth_q;
	logic [CAP-1:0] acc_q;
	logic [7:0] qsym_q;

	logic leaf_v_s1;
	logic [SW-1:0] leaf_sym_s1;
	logic [COUNT_BITS-1:0] cnt_rd_s1;
	logic scan_v_s1;
	logic [NW-1:0] scan_idx_s1;

	logic m_tvalid_q, m_tuser_q;
	logic [87:0] m_tdata_q;

	// strobes
	logic in_acc, out_free, leaf_hit;
	hcb_pkg::cmd_t cmd;
	logic [7:0] in_sym;
	logic sym_ok;
	logic [CNW-1:0] n_sum;
	logic w_we, p_we;
	logic [NW-1:0] w_waddr, p_waddr, w_raddr;
	logic [WB:0] w_wdata;
	logic [NW:0] p_wdata;
	hcb_pkg::scan_ctl_t scan_ctl;
	logic [NW-1:0] a_idx, b_idx;
	logic [WB-1:0] a_w, b_w;
	logic [CAP-1:0] code_fin;
	logic [LB-1:0] len_fin;
	logic q_ok;

	assign cmd      = hcb_pkg::cmd_t'(s_tuser);
	assign in_sym   = s_tdata[7:0];
	assign sym_ok   = {1'b0, in_sym} < 9'(SYMBOL_COUNT);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign leaf_hit = leaf_v_s1 && cnt_v_q[leaf_sym_s1] && (cnt_rd_s1 != '0);
	assign n_sum    = n_q + CNW'(leaf_hit);
	assign q_ok     = ({1'b0, qsym_q} < 9'(SYMBOL_COUNT)) && present_q[qsym_q[SW-1:0]];

	// final code from the walk register, root side kept on overflow
	always_comb begin
		if (int'(depth_q) >= CAP) begin
			len_fin  = LB'(CAP);
			code_fin = acc_q;
		end else begin
			len_fin  = LB'(depth_q);
			code_fin = acc_q >> (CAP - int'(depth_q));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hcb_pkg::ST_IDLE: begin
				if (in_acc && cmd == hcb_pkg::CMD_BUILD) state_d = hcb_pkg::ST_LEAF;
				else if (in_acc && cmd == hcb_pkg::CMD_QUERY) state_d = hcb_pkg::ST_QUERY;
			end
			hcb_pkg::ST_QUERY: begin
				if (out_free) state_d = hcb_pkg::ST_IDLE;
			end
			hcb_pkg::ST_LEAF: begin
				if (int'(i_q) == SYMBOL_COUNT - 1) state_d = hcb_pkg::ST_LEAF_END;
			end
			hcb_pkg::ST_LEAF_END: begin
				if (n_sum == '0) state_d = hcb_pkg::ST_REPORT;
				else if (int'(n_sum) == 1) state_d = hcb_pkg::ST_CODE_RD;
				else state_d = hcb_pkg::ST_SCAN;
			end
			hcb_pkg::ST_SCAN: begin
				if (k_q == NW'(top_q - 1'b1)) state_d = hcb_pkg::ST_SCAN_END;
			end
			hcb_pkg::ST_SCAN_END: state_d = hcb_pkg::ST_LINK_A;
			hcb_pkg::ST_LINK_A:   state_d = hcb_pkg::ST_LINK_B;
			hcb_pkg::ST_LINK_B:   state_d = hcb_pkg::ST_NEW;
			hcb_pkg::ST_NEW: begin
				if (int'(top_q) + 1 == 2 * int'(n_q) - 1) state_d = hcb_pkg::ST_CODE_RD;
				else state_d = hcb_pkg::ST_SCAN;
			end
			hcb_pkg::ST_CODE_RD:  state_d = hcb_pkg::ST_CODE_CHK;
			hcb_pkg::ST_CODE_CHK: begin
				if (wrd_q[WB]) state_d = hcb_pkg::ST_CODE_RD;
				else state_d = hcb_pkg::ST_CODE_WR;
			end
			hcb_pkg::ST_CODE_WR: begin
				if (int'(i_q) + 1 == int'(n_q)) state_d = hcb_pkg::ST_REPORT;
				else state_d = hcb_pkg::ST_CODE_RD;
			end
			hcb_pkg::ST_REPORT: begin
				if (out_free) state_d = hcb_pkg::ST_IDLE;
			end
			default: state_d = hcb_pkg::ST_IDLE;
		endcase
	end

	// memory strobes and handshake
	always_comb begin
		s_tready = (state_q == hcb_pkg::ST_IDLE);
		w_we     = 1'b0;
		w_waddr  = NW'(n_q);
		w_wdata  = {1'b0, WB'(cnt_rd_s1)};
		p_we     = 1'b0;
		p_waddr  = a_idx;
		p_wdata  = {1'b0, top_q};
		w_raddr  = c_q;
		scan_ctl.clr    = 1'b0;
		scan_ctl.v      = scan_v_s1;
		scan_ctl.linked = wrd_q[WB];
		case (state_q)
			hcb_pkg::ST_LEAF, hcb_pkg::ST_LEAF_END: begin
				w_we = leaf_hit;
			end
			hcb_pkg::ST_SCAN: begin
				w_raddr      = k_q;
				scan_ctl.clr = (k_q == '0);
			end
			hcb_pkg::ST_LINK_A: begin
				w_we    = 1'b1;
				w_waddr = a_idx;
				w_wdata = {1'b1, a_w};
				p_we    = 1'b1;
			end
			hcb_pkg::ST_LINK_B: begin
				w_we    = 1'b1;
				w_waddr = b_idx;
				w_wdata = {1'b1, b_w};
				p_we    = 1'b1;
				p_waddr = b_idx;
				p_wdata = {1'b1, top_q};
			end
			hcb_pkg::ST_NEW: begin
				w_we    = 1'b1;
				w_waddr = top_q;
				w_wdata = {1'b0, a_w + b_w};
			end
			default: ;
		endcase
	end

	// count store, valid bits give the cleared reset value
	always_ff @(posedge clk) begin
		if (in_acc && cmd == hcb_pkg::CMD_LOAD && sym_ok) begin
			cnt_mem[in_sym[SW-1:0]] <= s_tdata[8 +: COUNT_BITS];
		end
		cnt_rd_s1 <= cnt_mem[i_q[SW-1:0]];
	end

	// node, leaf and code memories
	always_ff @(posedge clk) begin
		if (w_we) wmem[w_waddr] <= w_wdata;
		if (p_we) pmem[p_waddr] <= p_wdata;
		if (leaf_hit) lmem[SW'(n_q)] <= leaf_sym_s1;
		if (state_q == hcb_pkg::ST_CODE_WR) cmem[lrd_q] <= {len_fin, code_fin};
		wrd_q <= wmem[w_raddr];
		prd_q <= pmem[c_q];
		lrd_q <= lmem[i_q[SW-1:0]];
		// code entry held from the accepted query until its answer enters the result register
		if (state_q == hcb_pkg::ST_IDLE) crd_q <= cmem[in_sym[SW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= hcb_pkg::ST_IDLE;
			cnt_v_q    <= '0;
			present_q  <= '0;
			n_q        <= '0;
			leaf_v_s1  <= 1'b0;
			scan_v_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			leaf_v_s1 <= (state_q == hcb_pkg::ST_LEAF);
			scan_v_s1 <= (state_q == hcb_pkg::ST_SCAN);
			if ((state_q == hcb_pkg::ST_QUERY || state_q == hcb_pkg::ST_REPORT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (in_acc && cmd == hcb_pkg::CMD_LOAD && sym_ok) cnt_v_q[in_sym[SW-1:0]] <= 1'b1;
			if (in_acc && cmd == hcb_pkg::CMD_BUILD) begin
				present_q <= '0;
				n_q       <= '0;
			end
			if (leaf_hit) n_q <= n_sum;
			if (state_q == hcb_pkg::ST_CODE_WR) present_q[lrd_q] <= 1'b1;
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		leaf_sym_s1 <= i_q[SW-1:0];
		scan_idx_s1 <= k_q;
		case (state_q)
			hcb_pkg::ST_IDLE: begin
				i_q    <= '0;
				qsym_q <= in_sym;
			end
			hcb_pkg::ST_LEAF: begin
				i_q <= i_q + 1'b1;
			end
			hcb_pkg::ST_LEAF_END: begin
				top_q   <= NW'(n_sum);
				k_q     <= '0;
				i_q     <= '0;
				c_q     <= '0;
				depth_q <= '0;
			end
			hcb_pkg::ST_SCAN: begin
				k_q <= k_q + 1'b1;
			end
			hcb_pkg::ST_NEW: begin
				top_q   <= top_q + 1'b1;
				k_q     <= '0;
				i_q     <= '0;
				c_q     <= '0;
				depth_q <= '0;
			end
			hcb_pkg::ST_CODE_CHK: begin
				if (wrd_q[WB]) begin
					acc_q   <= {prd_q[NW], acc_q[CAP-1:1]};
					depth_q <= depth_q + 1'b1;
					c_q     <= prd_q[NW-1:0];
				end
			end
			hcb_pkg::ST_CODE_WR: begin
				i_q     <= i_q + 1'b1;
				c_q     <= NW'(i_q + 1'b1);
				depth_q <= '0;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == hcb_pkg::ST_QUERY && out_free) begin
			m_tuser_q <= hcb_pkg::KIND_QUERY;
			m_tdata_q <= {q_ok ? 64'(crd_q[CAP-1:0]) : 64'd0,
				q_ok ? crd_q[LB+CAP-1:CAP] : 6'd0,
				q_ok, qsym_q, 9'(n_q)};
		end else if (state_q == hcb_pkg::ST_REPORT && out_free) begin
			m_tuser_q <= hcb_pkg::KIND_BUILD;
			m_tdata_q <= {79'd0, 9'(n_q)};
		end
	end

	hcb_min_pair #(
		.IDX_BITS(NW)
	) u_min_pair (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (scan_ctl),
		.idx    (scan_idx_s1),
		.weight (wrd_q[WB-1:0]),
		.a_idx  (a_idx),
		.a_w    (a_w),
		.b_idx  (b_idx),
		.b_w    (b_w)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// the two merged nodes are distinct
	a_pair_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcb_pkg::ST_LINK_A |-> a_idx != b_idx)
		else $error("merge picked one node twice");

	// a leaf path is shorter than the leaf count
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcb_pkg::ST_CODE_CHK |-> int'(depth_q) < int'(n_q))
		else $error("code walk too deep");

	// leaf count stays within the symbol alphabet
	a_leaf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(n_q) <= SYMBOL_COUNT)
		else $error("leaf count overflow");

	// a scan only runs with at least two open nodes
	a_scan_top: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcb_pkg::ST_SCAN |-> int'(top_q) >= 2)
		else $error("scan over fewer than two nodes");

endmodule
